// File: hw/rtl/assert_macros.svh
// shared assertion macros, empty when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CHK_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define CHK_NOW(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/pac_pkg.sv
package pac_pkg;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int LEN_W  = 6;
  localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ATTEMPT = 2'd1,
    EV_ACCEPT  = 2'd2,
    EV_REJECT  = 2'd3
  } event_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [1:0] KIND_SYN    = 2'd1;
  localparam logic [1:0] KIND_SYNACK = 2'd2;

  localparam logic CFG_LOCAL_NET = 1'b0;
  localparam logic CFG_LOCAL_LEN = 1'b1;

  localparam logic [ADDR_W-1:0] LOCAL_NET_RST = 32'h0A61_0000;
  localparam logic [LEN_W-1:0]  LOCAL_LEN_RST = 6'd16;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

  // leading-bit compare, zero length matches everything
  function automatic logic prefix_hit(input logic [ADDR_W-1:0] addr,
                                      input logic [ADDR_W-1:0] value,
                                      input logic [LEN_W-1:0]  len);
    logic [ADDR_W-1:0] mask;
    mask = ~({ADDR_W{1'b1}} >> clamp_len(len));
    return ((addr ^ value) & mask) == '0;
  endfunction

endpackage

// File: hw/rtl/pac_cell.sv
module pac_cell #(
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load_en,
  input  logic [CNT_W-1:0]          count,
  input  logic [pac_pkg::ADDR_W-1:0] load_value,
  input  logic [pac_pkg::LEN_W-1:0]  load_len,
  input  logic [pac_pkg::ADDR_W-1:0] query_addr,
  input  logic                      tok_in,
  input  logic                      hit_in,
  output logic                      tok_out,
  output logic                      hit_out
);
  import pac_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  logic [ADDR_W-1:0] value;
  logic [LEN_W-1:0]  len;
  logic              active;
  logic              tok;
  logic              hit;

  // entry is live once the fill count has passed it
  assign active = count > MY_IDX;

  always_ff @(posedge clk) begin
    if (load_en && count == MY_IDX) begin
      value <= load_value;
      len   <= clamp_len(load_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_in | (active & prefix_hit(query_addr, value, len));
  end

  assign tok_out = tok;
  assign hit_out = hit;

endmodule

// File: hw/rtl/ipv4_prefix_access_classifier.sv
// channel | dir | tdata (low bit up)                                   | tuser
// s_      | in  | prefix_value, prefix_length, src_addr, src_port,      | op
//         |     | dst_addr, dst_port, pkt_kind                          |
// m_      | out | remote_addr, remote_port, server_addr, server_port    | event_res
// cfg     | in  | cfg_we, cfg_index, cfg_data (write only)              | -
//
// a load or a check with no table lookup goes from accept to the done state and then
// to the result register; a check with the trusted lookup first raises the start token,
// and the query token walks the chain of prefix cells one cell per cycle
// one beat is in flight at a time; the result register lets the next beat in while
// a result waits on m_tready
// rst is synchronous; it clears the fill count, the token chain and the handshakes
module ipv4_prefix_access_classifier #(
  parameter int MAX_PREFIXES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // prefix_value, prefix_length, src_addr, src_port,
                                 // dst_addr, dst_port, pkt_kind
  input  logic         s_tuser,  // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // remote_addr, remote_port, server_addr, server_port
  output logic [1:0]   m_tuser,  // event_res
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import pac_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_PREFIXES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PREFIXES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // input beat fields
  logic              in_op;
  logic [ADDR_W-1:0] in_pvalue;
  logic [LEN_W-1:0]  in_plen;
  logic [ADDR_W-1:0] in_saddr;
  logic [PORT_W-1:0] in_sport;
  logic [ADDR_W-1:0] in_daddr;
  logic [PORT_W-1:0] in_dport;
  logic [1:0]        in_kind;

  assign in_op     = s_tuser;
  assign in_pvalue = s_tdata[31:0];
  assign in_plen   = s_tdata[37:32];
  assign in_saddr  = s_tdata[69:38];
  assign in_sport  = s_tdata[85:70];
  assign in_daddr  = s_tdata[117:86];
  assign in_dport  = s_tdata[133:118];
  assign in_kind   = s_tdata[135:134];

  // config registers
  logic [ADDR_W-1:0] local_net;
  logic [LEN_W-1:0]  local_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_net <= LOCAL_NET_RST;
      local_len <= LOCAL_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_NET: local_net <= cfg_data;
        CFG_LOCAL_LEN: local_len <= cfg_data[LEN_W-1:0];
        default:       local_net <= local_net;
      endcase
    end
  end

  logic in_acc;
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // fill count of the prefix table
  logic [CNT_W-1:0] count;
  logic             load_en;
  logic             load_full;

  assign load_full = (count == CNT_FULL);
  assign load_en   = in_acc && (in_op == OP_LOAD) && !load_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load_en) begin
      count <= count + CNT_W'(1);
    end
  end

  // local-net classification at accept; the trusted lookup comes later
  logic src_local, dst_local;
  logic want_scan;
  event_t ev_pre;

  assign src_local = prefix_hit(in_saddr, local_net, local_len);
  assign dst_local = prefix_hit(in_daddr, local_net, local_len);

  always_comb begin
    want_scan = 1'b0;
    ev_pre    = EV_NONE;
    if (in_op == OP_LOAD) begin
      ev_pre = load_full ? EV_REJECT : EV_NONE;
    end else if (in_kind == KIND_SYN && !src_local && dst_local) begin
      want_scan = 1'b1;
      ev_pre    = EV_ATTEMPT;
    end else if (in_kind == KIND_SYNACK && src_local && !dst_local) begin
      want_scan = 1'b1;
      ev_pre    = EV_ACCEPT;
    end
  end

  // pending item
  event_t            pend_ev;
  logic              pend_scan;
  logic [ADDR_W-1:0] query_addr;
  logic [ADDR_W-1:0] pend_raddr, pend_saddr;
  logic [PORT_W-1:0] pend_rport, pend_sport;
  logic              start_tok;
  logic              scan_hit;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_ev   <= ev_pre;
      pend_scan <= want_scan;
      // remote side is the address that gets looked up
      if (in_kind == KIND_SYNACK) begin
        query_addr <= in_daddr;
        pend_raddr <= in_daddr;
        pend_rport <= in_dport;
        pend_saddr <= in_saddr;
        pend_sport <= in_sport;
      end else begin
        query_addr <= in_saddr;
        pend_raddr <= in_saddr;
        pend_rport <= in_sport;
        pend_saddr <= in_daddr;
        pend_sport <= in_dport;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_tok <= 1'b0;
    end else begin
      start_tok <= in_acc && want_scan;
    end
  end

  // chain of prefix cells, token and hit flag pass one cell per cycle
  logic [MAX_PREFIXES-1:0] tok_vec;
  logic [MAX_PREFIXES-1:0] hit_vec;

  for (genvar i = 0; i < MAX_PREFIXES; i++) begin : g_cell
    logic tok_in_i, hit_in_i;
    if (i == 0) begin : g_head
      assign tok_in_i = start_tok;
      assign hit_in_i = 1'b0;
    end else begin : g_link
      assign tok_in_i = tok_vec[i-1];
      assign hit_in_i = hit_vec[i-1];
    end
    pac_cell #(
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load_en    (load_en),
      .count      (count),
      .load_value (in_pvalue),
      .load_len   (in_plen),
      .query_addr (query_addr),
      .tok_in     (tok_in_i),
      .hit_in     (hit_in_i),
      .tok_out    (tok_vec[i]),
      .hit_out    (hit_vec[i])
    );
  end

  logic scan_end;
  assign scan_end = tok_vec[MAX_PREFIXES-1];

  always_ff @(posedge clk) begin
    if (scan_end) begin
      scan_hit <= hit_vec[MAX_PREFIXES-1];
    end
  end

  // result register
  logic   out_load;
  event_t ev_final;
  logic   ev_report;

  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign ev_final  = (pend_scan && scan_hit) ? EV_NONE : pend_ev;
  assign ev_report = (ev_final == EV_ATTEMPT) || (ev_final == EV_ACCEPT);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= ev_final;
      m_tdata <= ev_report ? {pend_sport, pend_saddr, pend_rport, pend_raddr} : '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) begin
        state_next = want_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: if (scan_end) begin
        state_next = ST_DONE;
      end
      ST_DONE: if (out_load) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // at most one query token in the chain
  `CHK_NOW(a_tok_single, clk, rst, 1'b1, $onehot0({start_tok, tok_vec}))
  // nothing in the chain while a new beat may come in
  `CHK_NOW(a_idle_chain, clk, rst, s_tready, tok_vec == '0 && !start_tok)
  // fill count stays within the table
  `CHK_NOW(a_count_range, clk, rst, 1'b1, count <= CNT_FULL)
  // a load into a full table leaves the count alone
  `CHK_NEXT(a_full_hold, clk, rst, in_acc && in_op == OP_LOAD && load_full, $stable(count))

endmodule
